FILE: rtl/mcsg_pkg.sv
// ----------------------------------------------------------------------------
// mcsg_pkg
// Shared widths, command codes and the step descriptor type of the midpoint
// circle span generator.
// ----------------------------------------------------------------------------
package mcsg_pkg;

	localparam int COORD_BITS  = 16;
	localparam int RADIUS_BITS = 14;
	localparam int OUT_BITS    = COORD_BITS + 1;
	localparam int MAJ_BITS    = RADIUS_BITS + 1;
	localparam int ERR_BITS    = RADIUS_BITS + 3;
	localparam int IDX_BITS    = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [IDX_BITS-1:0] LAST_IDX_FILL    = IDX_BITS'(3);
	localparam logic [IDX_BITS-1:0] LAST_IDX_OUTLINE = IDX_BITS'(7);

	// One octant step to be expanded into points or spans
	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [MAJ_BITS-1:0]          major;
		logic [MAJ_BITS-1:0]          minor;
		logic                         fill;
		logic                         done;
	} step_t;

endpackage

FILE: rtl/mcsg_front.sv
// ----------------------------------------------------------------------------
// mcsg_front
// Accepts commands, holds the running circle state and turns every command
// that produces output into a step descriptor for the queue.
// ----------------------------------------------------------------------------
module mcsg_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   command,
	input  logic signed [mcsg_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [mcsg_pkg::COORD_BITS-1:0] center_y,
	input  logic [mcsg_pkg::RADIUS_BITS-1:0]       radius,
	input  logic                                   fill_mode,
	input  logic                                   q_full,
	output logic                                   q_push,
	output mcsg_pkg::step_t                        q_data
);

	logic signed [mcsg_pkg::COORD_BITS-1:0] cx_q, cy_q;
	logic [mcsg_pkg::MAJ_BITS-1:0]          maj_q, min_q;
	logic signed [mcsg_pkg::ERR_BITS-1:0]   err_q;
	logic                                   fill_q, busy_q;

	logic                                   start;
	logic signed [mcsg_pkg::COORD_BITS-1:0] cx_c, cy_c;
	logic                                   fill_c;
	logic [mcsg_pkg::MAJ_BITS-1:0]          a0, b0, a1, b1, a_nxt;
	logic signed [mcsg_pkg::ERR_BITS-1:0]   e0, e1, e2, e_nxt;
	logic                                   neg, done;

	assign in_ready = !q_full;
	assign start    = (command == mcsg_pkg::CMD_START);
	assign q_push   = in_valid && in_ready && (start || busy_q);

	always_comb begin
		cx_c   = start ? center_x : cx_q;
		cy_c   = start ? center_y : cy_q;
		fill_c = start ? fill_mode : fill_q;
		a0     = start ? mcsg_pkg::MAJ_BITS'(radius) : maj_q;
		b0     = start ? '0 : min_q;
		e0     = start ? ($signed(mcsg_pkg::ERR_BITS'(radius)) - mcsg_pkg::ERR_BITS'(1)) : err_q;
		// error -= 2*(dy+1) - 1
		e1     = e0 - $signed(mcsg_pkg::ERR_BITS'({b0, 1'b1}));
		neg    = e1[mcsg_pkg::ERR_BITS-1];
		b1     = b0 + mcsg_pkg::MAJ_BITS'(1);
		a1     = a0 - mcsg_pkg::MAJ_BITS'(1);
		e2     = e1 + $signed(mcsg_pkg::ERR_BITS'({a1, 1'b0}));
		a_nxt  = neg ? a1 : a0;
		e_nxt  = neg ? e2 : e1;
		// dx stepping below zero only happens on a zero radius, which finishes at once
		done   = (b1 > a_nxt) || (neg && (a0 == '0));
	end

	always_comb begin
		q_data.cx    = cx_c;
		q_data.cy    = cy_c;
		q_data.major = a0;
		q_data.minor = b0;
		q_data.fill  = fill_c;
		q_data.done  = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q   <= '0;
			cy_q   <= '0;
			maj_q  <= '0;
			min_q  <= '0;
			err_q  <= '0;
			fill_q <= 1'b0;
			busy_q <= 1'b0;
		end else if (q_push) begin
			cx_q   <= cx_c;
			cy_q   <= cy_c;
			maj_q  <= a_nxt;
			min_q  <= b1;
			err_q  <= e_nxt;
			fill_q <= fill_c;
			busy_q <= !done;
		end
	end

endmodule

FILE: rtl/mcsg_queue.sv
// ----------------------------------------------------------------------------
// mcsg_queue
// Short first-in first-out buffer of step descriptors between the command
// front end and the span emitter.
// ----------------------------------------------------------------------------
module mcsg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mcsg_pkg::step_t push_data,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output mcsg_pkg::step_t head
);

	mcsg_pkg::step_t                    entry_q [mcsg_pkg::QUEUE_DEPTH];
	logic [mcsg_pkg::QPTR_BITS-1:0]     wr_ptr_q, rd_ptr_q;
	logic [mcsg_pkg::QCNT_BITS-1:0]     count_q;

	assign full  = (count_q == mcsg_pkg::QCNT_BITS'(mcsg_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == mcsg_pkg::QPTR_BITS'(mcsg_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + mcsg_pkg::QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == mcsg_pkg::QPTR_BITS'(mcsg_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + mcsg_pkg::QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + mcsg_pkg::QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - mcsg_pkg::QCNT_BITS'(1);
			end
		end
	end

endmodule

FILE: rtl/mcsg_back.sv
// ----------------------------------------------------------------------------
// mcsg_back
// Expands the step descriptor at the queue head into eight points or four
// spans, one per cycle while the output is accepted, into a registered output stage.
// ----------------------------------------------------------------------------
module mcsg_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_empty,
	input  mcsg_pkg::step_t                       q_head,
	output logic                                  q_pop,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [mcsg_pkg::OUT_BITS-1:0]  x_from,
	output logic signed [mcsg_pkg::OUT_BITS-1:0]  x_to,
	output logic signed [mcsg_pkg::OUT_BITS-1:0]  y_pos,
	output logic                                  last_of_run,
	output logic                                  circle_done
);

	logic [mcsg_pkg::IDX_BITS-1:0]        idx_q;
	logic                                 valid_q;
	logic signed [mcsg_pkg::OUT_BITS-1:0] xf_q, xt_q, y_q;
	logic                                 last_q, done_q;

	logic                                 load, last_c;
	logic signed [mcsg_pkg::OUT_BITS-1:0] cx, cy, a, b;
	logic signed [mcsg_pkg::OUT_BITS-1:0] xpa, xma, xpb, xmb, ypa, yma, ypb, ymb;
	logic signed [mcsg_pkg::OUT_BITS-1:0] xf_c, xt_c, y_c;

	assign load  = !q_empty && (!valid_q || out_ready);
	assign q_pop = load && last_c;

	always_comb begin
		cx  = mcsg_pkg::OUT_BITS'(q_head.cx);
		cy  = mcsg_pkg::OUT_BITS'(q_head.cy);
		a   = $signed(mcsg_pkg::OUT_BITS'(q_head.major));
		b   = $signed(mcsg_pkg::OUT_BITS'(q_head.minor));
		xpa = cx + a;
		xma = cx - a;
		xpb = cx + b;
		xmb = cx - b;
		ypa = cy + a;
		yma = cy - a;
		ypb = cy + b;
		ymb = cy - b;
		last_c = q_head.fill ? (idx_q == mcsg_pkg::LAST_IDX_FILL)
		                     : (idx_q == mcsg_pkg::LAST_IDX_OUTLINE);
	end

	always_comb begin
		xf_c = xpa;
		xt_c = xpa;
		y_c  = ypb;
		if (q_head.fill) begin
			case (idx_q)
				3'd0: begin xf_c = xpa; xt_c = xma; y_c = ypb; end
				3'd1: begin xf_c = xpb; xt_c = xmb; y_c = ypa; end
				3'd2: begin xf_c = xma; xt_c = xpa; y_c = ymb; end
				3'd3: begin xf_c = xmb; xt_c = xpb; y_c = yma; end
				default: begin xf_c = xpa; xt_c = xma; y_c = ypb; end
			endcase
		end else begin
			case (idx_q)
				3'd0: begin xf_c = xpa; y_c = ypb; end
				3'd1: begin xf_c = xma; y_c = ypb; end
				3'd2: begin xf_c = xpb; y_c = ypa; end
				3'd3: begin xf_c = xmb; y_c = ypa; end
				3'd4: begin xf_c = xma; y_c = ymb; end
				3'd5: begin xf_c = xpa; y_c = ymb; end
				3'd6: begin xf_c = xmb; y_c = yma; end
				3'd7: begin xf_c = xpb; y_c = yma; end
				default: begin xf_c = xpa; y_c = ypb; end
			endcase
			xt_c = xf_c;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			xf_q   <= xf_c;
			xt_q   <= xt_c;
			y_q    <= y_c;
			last_q <= last_c;
			done_q <= last_c && q_head.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last_c ? '0 : idx_q + mcsg_pkg::IDX_BITS'(1);
			end else if (out_ready) begin
				// drop the item once its transfer completes
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = valid_q;
	assign x_from      = xf_q;
	assign x_to        = xt_q;
	assign y_pos       = y_q;
	assign last_of_run = last_q;
	assign circle_done = done_q;

endmodule

FILE: rtl/midpoint_circle_span_generator.sv
// ----------------------------------------------------------------------------
// midpoint_circle_span_generator
// Incremental midpoint circle rasterizer: start and step commands produce
// eight outline points or four horizontal spans per octant step.
// ----------------------------------------------------------------------------
// A command's first result is registered in the step queue and then in the
// output register of the span emitter. One result per cycle while out_ready is
// high; a step gives eight outline points or four fill spans.
// The command front end takes one command per cycle while the two-entry step
// queue has room. Reset (arst_n low) clears the circle state and the queue.
module midpoint_circle_span_generator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   command,
	input  logic signed [mcsg_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [mcsg_pkg::COORD_BITS-1:0] center_y,
	input  logic [mcsg_pkg::RADIUS_BITS-1:0]       radius,
	input  logic                                   fill_mode,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [mcsg_pkg::OUT_BITS-1:0]   x_from,
	output logic signed [mcsg_pkg::OUT_BITS-1:0]   x_to,
	output logic signed [mcsg_pkg::OUT_BITS-1:0]   y_pos,
	output logic                                   last_of_run,
	output logic                                   circle_done
);

	logic            q_full, q_empty, q_push, q_pop;
	mcsg_pkg::step_t q_wdata, q_head;

	mcsg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.fill_mode (fill_mode),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	mcsg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	mcsg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.x_from      (x_from),
		.x_to        (x_to),
		.y_pos       (y_pos),
		.last_of_run (last_of_run),
		.circle_done (circle_done)
	);

endmodule

FILE: tb/sv/tb_midpoint_circle_span_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midpoint_circle_span_generator
// Drives start and step commands into the circle span generator and checks
// every emitted point or span against a cycle-free prediction of the midpoint
// circle algorithm, with random idling on both channels and one long output
// stall that backs the block up into its command port.
// ----------------------------------------------------------------------------
module tb_midpoint_circle_span_generator;

	localparam int CLK_HALF     = 5;
	localparam int MAX_WAIT     = 13;
	localparam int RANDOM_ITEMS = 130;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 32;
	localparam int HOLD_AT      = 25;
	localparam int HOLD_CYCLES  = 300;

	typedef struct {
		logic                                   cmd;
		logic signed [mcsg_pkg::COORD_BITS-1:0] cx;
		logic signed [mcsg_pkg::COORD_BITS-1:0] cy;
		logic [mcsg_pkg::RADIUS_BITS-1:0]       r;
		logic                                   fill;
	} circle_cmd_t;

	typedef struct {
		logic signed [mcsg_pkg::OUT_BITS-1:0] xf;
		logic signed [mcsg_pkg::OUT_BITS-1:0] xt;
		logic signed [mcsg_pkg::OUT_BITS-1:0] yp;
		logic                                 last;
		logic                                 done;
	} span_t;

	logic                                   clk       = 1'b0;
	logic                                   arst_n    = 1'b0;
	logic                                   in_valid  = 1'b0;
	logic                                   command   = 1'b0;
	logic signed [mcsg_pkg::COORD_BITS-1:0] center_x  = '0;
	logic signed [mcsg_pkg::COORD_BITS-1:0] center_y  = '0;
	logic [mcsg_pkg::RADIUS_BITS-1:0]       radius    = '0;
	logic                                   fill_mode = 1'b0;
	logic                                   out_ready = 1'b0;
	logic                                   long_hold = 1'b0;
	logic                                   in_ready;
	logic                                   out_valid;
	logic signed [mcsg_pkg::OUT_BITS-1:0]   x_from;
	logic signed [mcsg_pkg::OUT_BITS-1:0]   x_to;
	logic signed [mcsg_pkg::OUT_BITS-1:0]   y_pos;
	logic                                   last_of_run;
	logic                                   circle_done;

	// predicted circle state
	int ctr_x = 0, ctr_y = 0, dx = 0, dy = 0, err_acc = 0;
	bit fill_on = 1'b0, circle_active = 1'b0;

	circle_cmd_t command_q[$];
	span_t       span_expect_q[$];
	circle_cmd_t cur_cmd;

	int total_items = 0, accepted_cnt = 0, err_cnt = 0, spans_checked = 0;
	int circles_started = 0, circles_fill = 0, circles_finished = 0, idle_steps = 0;
	int send_gap = 0, recv_wait = 0, hold_left = 0, cycle_cnt = 0;
	bit send_burst = 1'b0, recv_burst = 1'b0, hold_used = 1'b0;

	midpoint_circle_span_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.fill_mode   (fill_mode),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.x_from      (x_from),
		.x_to        (x_to),
		.y_pos       (y_pos),
		.last_of_run (last_of_run),
		.circle_done (circle_done)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic int draw_wait(bit burst);
		if (burst)
			return 0;
		return int'($urandom_range(0, MAX_WAIT));
	endfunction

	function automatic circle_cmd_t rand_command(logic cmd);
		circle_cmd_t c;
		c.cmd  = cmd;
		c.cx   = mcsg_pkg::COORD_BITS'($urandom);
		c.cy   = mcsg_pkg::COORD_BITS'($urandom);
		c.r    = mcsg_pkg::RADIUS_BITS'($urandom);
		c.fill = 1'($urandom);
		return c;
	endfunction

	function automatic circle_cmd_t start_cmd(
			logic signed [mcsg_pkg::COORD_BITS-1:0] cx,
			logic signed [mcsg_pkg::COORD_BITS-1:0] cy,
			logic [mcsg_pkg::RADIUS_BITS-1:0] r, logic fill);
		circle_cmd_t c;
		c.cmd  = mcsg_pkg::CMD_START;
		c.cx   = cx;
		c.cy   = cy;
		c.r    = r;
		c.fill = fill;
		return c;
	endfunction

	// number of octant steps a circle of radius r takes to finish
	function automatic int octant_steps(int r);
		int a, b, e, n;
		a = r;
		b = 0;
		e = r - 1;
		n = 0;
		while (b <= a) begin
			n++;
			b++;
			e = e - (2 * b - 1);
			if (e < 0) begin
				a--;
				e = e + 2 * a;
			end
		end
		return n;
	endfunction

	function automatic span_t make_span(int xf, int xt, int yp);
		span_t s;
		s.xf   = mcsg_pkg::OUT_BITS'(xf);
		s.xt   = mcsg_pkg::OUT_BITS'(xt);
		s.yp   = mcsg_pkg::OUT_BITS'(yp);
		s.last = 1'b0;
		s.done = 1'b0;
		return s;
	endfunction

	// queue the spans of the current octant step, then advance dx, dy and the error
	function automatic void emit_octant();
		span_t row [8];
		int n;
		if (fill_on) begin
			row[0] = make_span(ctr_x + dx, ctr_x - dx, ctr_y + dy);
			row[1] = make_span(ctr_x + dy, ctr_x - dy, ctr_y + dx);
			row[2] = make_span(ctr_x - dx, ctr_x + dx, ctr_y - dy);
			row[3] = make_span(ctr_x - dy, ctr_x + dy, ctr_y - dx);
			n = 4;
		end else begin
			row[0] = make_span(ctr_x + dx, ctr_x + dx, ctr_y + dy);
			row[1] = make_span(ctr_x - dx, ctr_x - dx, ctr_y + dy);
			row[2] = make_span(ctr_x + dy, ctr_x + dy, ctr_y + dx);
			row[3] = make_span(ctr_x - dy, ctr_x - dy, ctr_y + dx);
			row[4] = make_span(ctr_x - dx, ctr_x - dx, ctr_y - dy);
			row[5] = make_span(ctr_x + dx, ctr_x + dx, ctr_y - dy);
			row[6] = make_span(ctr_x - dy, ctr_x - dy, ctr_y - dx);
			row[7] = make_span(ctr_x + dy, ctr_x + dy, ctr_y - dx);
			n = 8;
		end
		dy = dy + 1;
		err_acc = err_acc - (2 * dy - 1);
		if (err_acc < 0) begin
			dx = dx - 1;
			err_acc = err_acc + 2 * dx;
		end
		row[n-1].last = 1'b1;
		if (dy > dx) begin
			row[n-1].done = 1'b1;
			circle_active = 1'b0;
			circles_finished++;
		end
		for (int k = 0; k < n; k++)
			span_expect_q.push_back(row[k]);
	endfunction

	function automatic void rasterize_command(circle_cmd_t c);
		if (c.cmd == mcsg_pkg::CMD_START) begin
			ctr_x = int'(c.cx);
			ctr_y = int'(c.cy);
			dx = int'(c.r);
			dy = 0;
			err_acc = dx - 1;
			fill_on = c.fill;
			circle_active = 1'b1;
			circles_started++;
			if (c.fill)
				circles_fill++;
			emit_octant();
		end else if (circle_active) begin
			emit_octant();
		end else begin
			idle_steps++;
		end
	endfunction

	function automatic void compare_field(string fname,
			logic signed [mcsg_pkg::OUT_BITS-1:0] want,
			logic signed [mcsg_pkg::OUT_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
			err_cnt++;
		end
	endfunction

	function automatic void check_span();
		span_t want;
		if (span_expect_q.size() == 0) begin
			$display("%0t: unexpected result x_from=%0d x_to=%0d y_pos=%0d", $time,
				x_from, x_to, y_pos);
			err_cnt++;
			return;
		end
		want = span_expect_q.pop_front();
		compare_field("x_from", want.xf, x_from);
		compare_field("x_to", want.xt, x_to);
		compare_field("y_pos", want.yp, y_pos);
		compare_field("last_of_run", mcsg_pkg::OUT_BITS'(want.last),
			mcsg_pkg::OUT_BITS'(last_of_run));
		compare_field("circle_done", mcsg_pkg::OUT_BITS'(want.done),
			mcsg_pkg::OUT_BITS'(circle_done));
		spans_checked++;
	endfunction

	// command driver: hold until transfer, then wait the drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				rasterize_command(cur_cmd);
				accepted_cnt++;
			end
			if (in_valid && !in_ready) begin
				// hold the offered command
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (command_q.size() != 0) begin
				cur_cmd = command_q.pop_front();
				command   <= cur_cmd.cmd;
				center_x  <= cur_cmd.cx;
				center_y  <= cur_cmd.cy;
				radius    <= cur_cmd.r;
				fill_mode <= cur_cmd.fill;
				in_valid  <= 1'b1;
				if ($urandom_range(0, 19) == 0)
					send_burst = !send_burst;
				send_gap = draw_wait(send_burst);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver pacing
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				check_span();
				if ($urandom_range(0, 19) == 0)
					recv_burst = !recv_burst;
				recv_wait = draw_wait(recv_burst);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			out_ready <= (recv_wait == 0) && !long_hold;
		end
	end

	// one long output stall so the step queue fills and the command port backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 1'b0;
			hold_left = 0;
			hold_used = 1'b0;
		end else if (!hold_used && accepted_cnt >= HOLD_AT) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES;
			long_hold <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			long_hold <= (hold_left != 0);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still outstanding", $time,
				span_expect_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		circle_cmd_t c;
		int steps, pick, counted;

		// directed: idle step, zero radius both modes, full-scale radius and
		// coordinates, restart while busy, then two complete small circles
		command_q.push_back(rand_command(mcsg_pkg::CMD_STEP));
		command_q.push_back(start_cmd(16'sh7FFF, 16'sh8000, '0, 1'b0));
		command_q.push_back(start_cmd(16'sh8000, 16'sh7FFF, '0, 1'b1));
		command_q.push_back(rand_command(mcsg_pkg::CMD_STEP));
		command_q.push_back(start_cmd(16'sh8000, 16'sh8000, '1, 1'b0));
		command_q.push_back(rand_command(mcsg_pkg::CMD_STEP));
		command_q.push_back(rand_command(mcsg_pkg::CMD_STEP));
		command_q.push_back(start_cmd(16'sh7FFF, 16'sh7FFF, '1, 1'b1));
		command_q.push_back(rand_command(mcsg_pkg::CMD_STEP));
		command_q.push_back(rand_command(mcsg_pkg::CMD_STEP));
		command_q.push_back(start_cmd(16'sh0000, 16'sh0000,
			mcsg_pkg::RADIUS_BITS'(3), 1'b0));
		repeat (octant_steps(3) - 1)
			command_q.push_back(rand_command(mcsg_pkg::CMD_STEP));
		command_q.push_back(rand_command(mcsg_pkg::CMD_STEP));
		command_q.push_back(start_cmd(16'sh0064, -16'sh0064,
			mcsg_pkg::RADIUS_BITS'(1), 1'b1));
		repeat (octant_steps(1) - 1)
			command_q.push_back(rand_command(mcsg_pkg::CMD_STEP));

		// random circles: mostly complete, some cut short by a new start,
		// some followed by stray steps, a few with a huge radius abandoned early
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			c = rand_command(mcsg_pkg::CMD_START);
			pick = 5;
			if ($urandom_range(0, 15) == 0) begin
				steps = int'($urandom_range(0, 3));
			end else begin
				c.r = mcsg_pkg::RADIUS_BITS'($urandom_range(0, 24));
				steps = octant_steps(int'(c.r)) - 1;
				pick = int'($urandom_range(0, 9));
				if (pick < 2)
					steps = int'($urandom_range(0, steps));
			end
			command_q.push_back(c);
			counted++;
			repeat (steps) begin
				command_q.push_back(rand_command(mcsg_pkg::CMD_STEP));
				counted++;
			end
			if (pick == 2) begin
				repeat ($urandom_range(1, 2))
					command_q.push_back(rand_command(mcsg_pkg::CMD_STEP));
			end
		end
		total_items = command_q.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_cnt < total_items || span_expect_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands: %0d circles started (%0d filled), %0d finished,",
			total_items, circles_started, circles_fill, circles_finished);
		$display("%0d idle steps; checked %0d points and spans, %0d mismatches.",
			idle_steps, spans_checked, err_cnt);
		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
